[rtl/mcg_pkg.sv]
// Package for the month calendar grid generator.
// Holds the transfer payload types, the setup result struct, state enums and calendar tables.
// No dependencies.
package mcg_pkg;

  localparam int unsigned YEAR_W  = 14;
  localparam int unsigned MONTH_W = 4;
  localparam int unsigned DAY_W   = 5;
  localparam int unsigned ROW_W   = 3;
  localparam int unsigned COL_W   = 3;
  localparam int unsigned CFG_W   = 14;
  localparam int unsigned IDX_W   = 2;

  localparam logic [YEAR_W-1:0]  YEAR_MIN  = 14'd1;
  localparam logic [YEAR_W-1:0]  YEAR_MAX  = 14'd9999;
  localparam logic [MONTH_W-1:0] MONTH_MIN = 4'd1;
  localparam logic [MONTH_W-1:0] MONTH_MAX = 4'd12;
  localparam logic [MONTH_W-1:0] MONTH_FEB = 4'd2;
  localparam logic [MONTH_W-1:0] MONTH_MAR = 4'd3;

  // Reciprocal for divide by 100: q = (y * 5243) >> 19, exact for y < 43690
  localparam logic [12:0] DIV100_MUL   = 13'd5243;
  localparam int unsigned DIV100_SHIFT = 19;

  // Configuration register indexes
  localparam logic [IDX_W-1:0] REG_TODAY_YEAR  = 2'd0;
  localparam logic [IDX_W-1:0] REG_TODAY_MONTH = 2'd1;
  localparam logic [IDX_W-1:0] REG_TODAY_DAY   = 2'd2;

  localparam logic [YEAR_W-1:0]  TODAY_YEAR_RST  = 14'd1970;
  localparam logic [MONTH_W-1:0] TODAY_MONTH_RST = 4'd1;
  localparam logic [DAY_W-1:0]   TODAY_DAY_RST   = 5'd1;

  typedef struct packed {
    logic [YEAR_W-1:0]  year;
    logic [MONTH_W-1:0] month;
  } in_item_t;

  typedef struct packed {
    logic [DAY_W-1:0] day_number;
    logic [ROW_W-1:0] grid_row;
    logic [COL_W-1:0] weekday_column;
    logic             is_today;
    logic             last_day;
  } out_item_t;

  // Setup unit to top level
  typedef struct packed {
    logic             done;
    logic [COL_W-1:0] first_weekday;
    logic [DAY_W-1:0] month_length;
  } setup_res_t;

  typedef enum logic [1:0] {
    TOP_IDLE,
    TOP_SETUP,
    TOP_EMIT
  } top_state_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_QY,
    S_RY,
    S_QA,
    S_RA,
    S_SUM,
    S_MOD
  } setup_state_t;

  // Days in a month, February taking the leap flag
  function automatic logic [DAY_W-1:0] month_len(input logic [MONTH_W-1:0] m,
                                                 input logic leap);
    logic [DAY_W-1:0] len;
    case (m)
      4'd2:                      len = leap ? 5'd29 : 5'd28;
      4'd4, 4'd6, 4'd9, 4'd11:   len = 5'd30;
      default:                   len = 5'd31;
    endcase
    return len;
  endfunction

  // Zeller month term floor(26 * (m + 1) / 10) for m in 3..14
  function automatic logic [5:0] zeller_term(input logic [MONTH_W-1:0] m);
    logic [5:0] t;
    case (m)
      4'd3:    t = 6'd10;
      4'd4:    t = 6'd13;
      4'd5:    t = 6'd15;
      4'd6:    t = 6'd18;
      4'd7:    t = 6'd20;
      4'd8:    t = 6'd23;
      4'd9:    t = 6'd26;
      4'd10:   t = 6'd28;
      4'd11:   t = 6'd31;
      4'd12:   t = 6'd33;
      4'd13:   t = 6'd36;
      4'd14:   t = 6'd39;
      default: t = 6'd0;
    endcase
    return t;
  endfunction

endpackage

[rtl/mcg_setup.sv]
// Setup sequencer: weekday of the first and month length for one request.
// One shared divide-by-100 multiplier and one shared subtractor, reused step by step.
// Depends on mcg_pkg.
module mcg_setup (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          start,
  input  logic [mcg_pkg::YEAR_W-1:0]    year,
  input  logic [mcg_pkg::MONTH_W-1:0]   month,
  output mcg_pkg::setup_res_t           res
);
  import mcg_pkg::*;

  setup_state_t state, state_next;

  logic [YEAR_W-1:0]  yr;     // year as given, for the leap rule
  logic [YEAR_W-1:0]  ya;     // year shifted for Jan/Feb
  logic [MONTH_W-1:0] mz;     // month shifted for Jan/Feb
  logic [MONTH_W-1:0] mon;
  logic [6:0]         q;      // quotient by 100
  logic [6:0]         k;
  logic [6:0]         c;
  logic               leap;
  logic [9:0]         f;
  logic [2:0]         cnt;
  logic [DAY_W-1:0]   len;

  logic [YEAR_W-1:0]  dv_op;
  logic [26:0]        prod;
  logic [6:0]         quot;
  logic [YEAR_W-1:0]  minuend;
  logic [YEAR_W-1:0]  subtrahend;
  logic [YEAR_W-1:0]  diff;
  logic               ge;
  logic [9:0]         sum;

  // Shared divide-by-100 multiplier
  assign dv_op = (state == S_QA) ? ya : yr;
  assign prod  = dv_op * DIV100_MUL;
  assign quot  = prod[DIV100_SHIFT+6:DIV100_SHIFT];

  // Shared subtractor: remainder by 100, then restoring mod 7
  always_comb begin
    unique case (state)
      S_RY: begin
        minuend    = yr;
        subtrahend = {q, 6'd0} + {1'b0, q, 5'd0} + {4'd0, q, 2'd0} + 14'd0;
      end
      S_RA: begin
        minuend    = ya;
        subtrahend = {q, 6'd0} + {1'b0, q, 5'd0} + {4'd0, q, 2'd0} + 14'd0;
      end
      S_MOD: begin
        minuend    = {4'd0, f};
        subtrahend = YEAR_W'(14'd7 << cnt);
      end
      default: begin
        minuend    = '0;
        subtrahend = '0;
      end
    endcase
  end
  assign diff = minuend - subtrahend;
  assign ge   = (minuend >= subtrahend);

  // Zeller sum with the +6 that shifts Saturday-first to Sunday-first
  assign sum = 10'd7 + {4'd0, zeller_term(mz)} + {3'd0, k} + {5'd0, k[6:2]}
             + {5'd0, c[6:2]} + {1'b0, c, 2'd0} + {3'd0, c};

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Next state and result
  always_comb begin
    state_next        = state;
    res.done          = 1'b0;
    res.first_weekday = ge ? diff[2:0] : f[2:0];
    res.month_length  = len;
    unique case (state)
      S_IDLE: if (start) state_next = S_QY;
      S_QY:   state_next = S_RY;
      S_RY:   state_next = S_QA;
      S_QA:   state_next = S_RA;
      S_RA:   state_next = S_SUM;
      S_SUM:  state_next = S_MOD;
      S_MOD: begin
        if (cnt == 3'd0) begin
          res.done   = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  // Datapath registers
  always_ff @(posedge clk) begin
    case (state)
      S_IDLE: begin
        if (start) begin
          yr  <= year;
          mon <= month;
          if (month < MONTH_MAR) begin
            ya <= year - YEAR_W'(1);
            mz <= month + MONTH_W'(12);
          end else begin
            ya <= year;
            mz <= month;
          end
        end
      end
      S_QY, S_QA: q <= quot;
      S_RY: leap <= ((yr[1:0] == 2'd0) && (diff != '0)) ||
                    ((diff == '0) && (q[1:0] == 2'd0));
      S_RA: begin
        k <= diff[6:0];
        c <= q;
      end
      S_SUM: begin
        f   <= sum;
        cnt <= 3'd6;
        len <= month_len(mon, leap);
      end
      S_MOD: begin
        if (ge) f <= diff[9:0];
        cnt <= cnt - 3'd1;
      end
      default: ;
    endcase
  end

endmodule

[rtl/month_calendar_grid_generator.sv]
// Month calendar grid generator, top level.
// Setup follows the input transfer: quotient and remainder by 100 of the year and of the
// Jan/Feb-shifted year, the Zeller sum, seven restoring mod-7 steps. The first day is then
// offered, then one day result per cycle while out_stall is low, 28 to 31 results.
// Input stalls until the last day is transferred. Synchronous reset returns to idle with
// today set to 1970-01-01.
module month_calendar_grid_generator (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        in_valid,
  output logic                        in_stall,
  input  mcg_pkg::in_item_t           in_item,
  output logic                        out_valid,
  input  logic                        out_stall,
  output mcg_pkg::out_item_t          out_item,
  input  logic                        cfg_we,
  input  logic [mcg_pkg::IDX_W-1:0]   cfg_index,
  input  logic [mcg_pkg::CFG_W-1:0]   cfg_data
);
  import mcg_pkg::*;

  top_state_t state, state_next;

  logic [YEAR_W-1:0]  today_year;
  logic [MONTH_W-1:0] today_month;
  logic [DAY_W-1:0]   today_day;

  logic [DAY_W-1:0]   day;
  logic [ROW_W-1:0]   row;
  logic [COL_W-1:0]   col;
  logic [DAY_W-1:0]   len;
  logic               tim;

  logic [YEAR_W-1:0]  ys;
  logic [MONTH_W-1:0] ms;
  logic               in_xfer;
  logic               out_xfer;
  logic               is_last;
  setup_res_t         setup_res;

  // Saturate the request
  assign ys = (in_item.year == '0) ? YEAR_MIN :
              (in_item.year > YEAR_MAX) ? YEAR_MAX : in_item.year;
  assign ms = (in_item.month == '0) ? MONTH_MIN :
              (in_item.month > MONTH_MAX) ? MONTH_MAX : in_item.month;

  assign in_stall = (state != TOP_IDLE);
  assign in_xfer  = in_valid && !in_stall;
  assign out_valid = (state == TOP_EMIT);
  assign out_xfer  = out_valid && !out_stall;
  assign is_last   = (day == len);

  mcg_setup u_setup (
    .clk   (clk),
    .rst   (rst),
    .start (in_xfer),
    .year  (ys),
    .month (ms),
    .res   (setup_res)
  );

  // Configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      today_year  <= TODAY_YEAR_RST;
      today_month <= TODAY_MONTH_RST;
      today_day   <= TODAY_DAY_RST;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_TODAY_YEAR:  today_year  <= cfg_data[YEAR_W-1:0];
        REG_TODAY_MONTH: today_month <= cfg_data[MONTH_W-1:0];
        REG_TODAY_DAY:   today_day   <= cfg_data[DAY_W-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= TOP_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      TOP_IDLE:  if (in_xfer) state_next = TOP_SETUP;
      TOP_SETUP: if (setup_res.done) state_next = TOP_EMIT;
      TOP_EMIT:  if (out_xfer && is_last) state_next = TOP_IDLE;
      default:   state_next = TOP_IDLE;
    endcase
  end

  // Day walker across the Sunday-first grid
  always_ff @(posedge clk) begin
    if (in_xfer) begin
      tim <= (ys == today_year) && (ms == today_month);
    end
    if (state == TOP_SETUP && setup_res.done) begin
      len <= setup_res.month_length;
      day <= DAY_W'(1);
      row <= '0;
      col <= setup_res.first_weekday;
    end else if (out_xfer && !is_last) begin
      day <= day + DAY_W'(1);
      if (col == COL_W'(6)) begin
        col <= '0;
        row <= row + ROW_W'(1);
      end else begin
        col <= col + COL_W'(1);
      end
    end
  end

  assign out_item.day_number     = day;
  assign out_item.grid_row       = row;
  assign out_item.weekday_column = col;
  assign out_item.is_today       = tim && (day == today_day);
  assign out_item.last_day       = is_last;

endmodule
